@@ rtl/ampc_pkg.sv @@
// shared types, codes and helpers for the armed motor pulse controller
// no dependencies; imported by armed_motor_pulse_controller_unit
package ampc_pkg;

  localparam int ACTION_W    = 3;
  localparam int MOTOR_NUM_W = 8;
  localparam int DUTY_IN_W   = 12;
  localparam int DURATION_W  = 16;
  localparam int ERROR_W     = 3;
  localparam int MAG_W       = 10;
  localparam int REPORTED    = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // pwm ceiling applied to every reported magnitude
  localparam logic [15:0] PWM_LIMIT = 16'd1023;

  localparam logic [MAG_W-1:0]      MAX_DUTY_RESET     = 10'd1023;
  localparam logic [DURATION_W-1:0] MAX_DURATION_RESET = 16'd5000;
  localparam logic [DURATION_W-1:0] ARM_TIMEOUT_RESET  = 16'd2000;

  typedef logic signed [DUTY_IN_W-1:0] duty_in_t;
  typedef logic signed [MAG_W:0]       duty_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 3'd0,
    ACT_ARM    = 3'd1,
    ACT_DISARM = 3'd2,
    ACT_PULSE  = 3'd3,
    ACT_WHEELS = 3'd4
  } action_t;

  typedef enum logic [ERROR_W-1:0] {
    ERR_NONE        = 3'd0,
    ERR_DISARMED    = 3'd1,
    ERR_ARM_TIMEOUT = 3'd2,
    ERR_REFUSED     = 3'd3,
    ERR_BAD_MOTOR   = 3'd4
  } err_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_DUTY     = 2'd0,
    REG_MAX_DURATION = 2'd1,
    REG_ARM_TIMEOUT  = 2'd2,
    REG_INVERT_MASK  = 2'd3
  } cfg_reg_t;

  // symmetric saturation of a commanded duty at +/- lim
  function automatic duty_t clamp_duty(input duty_in_t d, input logic [MAG_W-1:0] lim);
    logic signed [DUTY_IN_W-1:0] lim_s;
    logic signed [DUTY_IN_W-1:0] res;
    lim_s = signed'({2'b00, lim});
    if (d > lim_s) begin
      res = lim_s;
    end else if (d < -lim_s) begin
      res = -lim_s;
    end else begin
      res = d;
    end
    return duty_t'(res);
  endfunction

endpackage

@@ rtl/armed_motor_pulse_controller_unit.sv @@
// armed motor pulse controller: command decode, watchdog, stop timers, pwm outputs
// depends on ampc_pkg
//
// One command request is taken per clock unless stalled: tick, arm, disarm, a timed
// pulse on one motor, or timed duties for all four wheels. All next-state and result
// logic is a single combinational pass from the request ports into the state
// registers and a one-deep result register, so an accepted request's result appears
// in the next cycle. in_stall rises only while a finished result waits on out_stall.
// Motion requests are refused unless armed; every accepted motion request reloads
// the arm watchdog, and when it runs out all motors stop and the unit disarms.
// Configuration writes are expected only while no request is in flight.
module armed_motor_pulse_controller_unit #(
  parameter int MOTOR_TOTAL = 4,
  parameter int TIMER_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write_enable,
  input  logic [ampc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ampc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ampc_pkg::ACTION_W-1:0]        action,
  input  logic [ampc_pkg::MOTOR_NUM_W-1:0]     motor_number,
  input  logic signed [ampc_pkg::DUTY_IN_W-1:0] pulse_duty,
  input  logic signed [ampc_pkg::DUTY_IN_W-1:0] duty_front_left,
  input  logic signed [ampc_pkg::DUTY_IN_W-1:0] duty_front_right,
  input  logic signed [ampc_pkg::DUTY_IN_W-1:0] duty_rear_left,
  input  logic signed [ampc_pkg::DUTY_IN_W-1:0] duty_rear_right,
  input  logic [ampc_pkg::DURATION_W-1:0]      duration_ms,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 accepted,
  output logic [ampc_pkg::ERROR_W-1:0]         error_code,
  output logic                                 is_armed,
  output logic [ampc_pkg::REPORTED-1:0]        direction_bits,
  output logic [ampc_pkg::MAG_W-1:0]           magnitude_motor_one,
  output logic [ampc_pkg::MAG_W-1:0]           magnitude_motor_two,
  output logic [ampc_pkg::MAG_W-1:0]           magnitude_motor_three,
  output logic [ampc_pkg::MAG_W-1:0]           magnitude_motor_four
);
  import ampc_pkg::*;

  // configuration registers
  logic [MAG_W-1:0]      max_duty;
  logic [DURATION_W-1:0] max_duration_ms;
  logic [DURATION_W-1:0] arm_timeout_ms;
  logic [REPORTED-1:0]   invert_mask;

  // control state
  logic                  armed_flag, armed_flag_next;
  logic [TIMER_BITS-1:0] watchdog, watchdog_next;
  logic [TIMER_BITS-1:0] stop_cnt [MOTOR_TOTAL];
  logic [TIMER_BITS-1:0] stop_cnt_next [MOTOR_TOTAL];
  duty_t                 motor_duty [MOTOR_TOTAL];
  duty_t                 motor_duty_next [MOTOR_TOTAL];
  err_t                  last_error, last_error_next;
  logic                  ok;

  // request decode helpers
  logic                  in_accept;
  duty_t                 wheel_clamped [REPORTED];
  duty_t                 wheel_duty [MOTOR_TOTAL];
  duty_t                 pulse_clamped;
  logic                  wheel_motion;
  logic                  motor_bad;
  logic [DURATION_W-1:0] dur_sat;
  logic [31:0]           dur_ext;
  logic [TIMER_BITS-1:0] dur_load;
  logic [31:0]           timeout_ext;
  logic [TIMER_BITS-1:0] timeout_load;
  logic [TIMER_BITS-1:0] watchdog_dec;

  // result path
  duty_t                 rep_duty [REPORTED];
  logic [MAG_W-1:0]      mag [REPORTED];
  logic [REPORTED-1:0]   dir;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign wheel_clamped[0] = clamp_duty(duty_front_left, max_duty);
  assign wheel_clamped[1] = clamp_duty(duty_front_right, max_duty);
  assign wheel_clamped[2] = clamp_duty(duty_rear_left, max_duty);
  assign wheel_clamped[3] = clamp_duty(duty_rear_right, max_duty);
  assign pulse_clamped    = clamp_duty(pulse_duty, max_duty);
  assign wheel_motion     = (wheel_clamped[0] != '0) || (wheel_clamped[1] != '0) ||
                            (wheel_clamped[2] != '0) || (wheel_clamped[3] != '0);
  assign motor_bad        = (motor_number == '0) ||
                            (motor_number > MOTOR_NUM_W'(MOTOR_TOTAL));

  // clamp to max first, then raise to one; loaded values keep TIMER_BITS
  always_comb begin
    dur_sat = (duration_ms > max_duration_ms) ? max_duration_ms : duration_ms;
    if (dur_sat == '0) begin
      dur_sat = DURATION_W'(1);
    end
  end
  assign dur_ext      = {{(32 - DURATION_W){1'b0}}, dur_sat};
  assign dur_load     = dur_ext[TIMER_BITS-1:0];
  assign timeout_ext  = {{(32 - DURATION_W){1'b0}}, arm_timeout_ms};
  assign timeout_load = timeout_ext[TIMER_BITS-1:0];
  assign watchdog_dec = (watchdog != '0) ? watchdog - TIMER_BITS'(1) : '0;

  // motors past the four wheels get zero duty from a wheel request
  for (genvar g = 0; g < MOTOR_TOTAL; g++) begin : g_wheel
    if (g < REPORTED) begin : g_used
      assign wheel_duty[g] = wheel_clamped[g];
    end else begin : g_extra
      assign wheel_duty[g] = '0;
    end
  end

  always_comb begin
    armed_flag_next = armed_flag;
    watchdog_next   = watchdog;
    last_error_next = last_error;
    ok              = 1'b1;
    for (int i = 0; i < MOTOR_TOTAL; i++) begin
      stop_cnt_next[i]   = stop_cnt[i];
      motor_duty_next[i] = motor_duty[i];
    end

    unique case (action_t'(action))
      ACT_TICK: begin
        if (armed_flag && (watchdog_dec == '0)) begin
          // watchdog expired
          armed_flag_next = 1'b0;
          watchdog_next   = '0;
          last_error_next = ERR_ARM_TIMEOUT;
          for (int i = 0; i < MOTOR_TOTAL; i++) begin
            stop_cnt_next[i]   = '0;
            motor_duty_next[i] = '0;
          end
        end else begin
          if (armed_flag) begin
            watchdog_next = watchdog_dec;
          end
          for (int i = 0; i < MOTOR_TOTAL; i++) begin
            if (stop_cnt[i] != '0) begin
              stop_cnt_next[i] = stop_cnt[i] - TIMER_BITS'(1);
              if (stop_cnt_next[i] == '0) begin
                motor_duty_next[i] = '0;
              end
            end
          end
        end
      end
      ACT_ARM: begin
        armed_flag_next = 1'b1;
        watchdog_next   = timeout_load;
        last_error_next = ERR_NONE;
        for (int i = 0; i < MOTOR_TOTAL; i++) begin
          stop_cnt_next[i]   = '0;
          motor_duty_next[i] = '0;
        end
      end
      ACT_DISARM: begin
        armed_flag_next = 1'b0;
        watchdog_next   = '0;
        last_error_next = ERR_DISARMED;
        for (int i = 0; i < MOTOR_TOTAL; i++) begin
          stop_cnt_next[i]   = '0;
          motor_duty_next[i] = '0;
        end
      end
      ACT_PULSE: begin
        priority if (motor_bad) begin
          ok              = 1'b0;
          last_error_next = ERR_BAD_MOTOR;
        end else if (pulse_clamped == '0) begin
          last_error_next = ERR_NONE;
          for (int i = 0; i < MOTOR_TOTAL; i++) begin
            if (motor_number == MOTOR_NUM_W'(i + 1)) begin
              stop_cnt_next[i]   = '0;
              motor_duty_next[i] = '0;
            end
          end
        end else if (!armed_flag) begin
          ok              = 1'b0;
          last_error_next = ERR_REFUSED;
        end else begin
          watchdog_next   = timeout_load;
          last_error_next = ERR_NONE;
          for (int i = 0; i < MOTOR_TOTAL; i++) begin
            if (motor_number == MOTOR_NUM_W'(i + 1)) begin
              stop_cnt_next[i]   = dur_load;
              motor_duty_next[i] = pulse_clamped;
            end
          end
        end
      end
      ACT_WHEELS: begin
        priority if (!wheel_motion) begin
          last_error_next = ERR_NONE;
          for (int i = 0; i < MOTOR_TOTAL; i++) begin
            stop_cnt_next[i]   = '0;
            motor_duty_next[i] = '0;
          end
        end else if (!armed_flag) begin
          ok              = 1'b0;
          last_error_next = ERR_REFUSED;
        end else begin
          watchdog_next   = timeout_load;
          last_error_next = ERR_NONE;
          for (int i = 0; i < MOTOR_TOTAL; i++) begin
            stop_cnt_next[i]   = dur_load;
            motor_duty_next[i] = wheel_duty[i];
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // reported motors; ones that do not exist read as stopped
  for (genvar g = 0; g < REPORTED; g++) begin : g_rep
    if (g < MOTOR_TOTAL) begin : g_real
      assign rep_duty[g] = motor_duty_next[g];
      assign dir[g]      = rep_duty[g][MAG_W] ^ invert_mask[g];
    end else begin : g_absent
      assign rep_duty[g] = '0;
      assign dir[g]      = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < REPORTED; i++) begin
      mag[i] = rep_duty[i][MAG_W] ? MAG_W'(-rep_duty[i]) : MAG_W'(rep_duty[i]);
      if ({{(16 - MAG_W){1'b0}}, mag[i]} > PWM_LIMIT) begin
        mag[i] = PWM_LIMIT[MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty        <= MAX_DUTY_RESET;
      max_duration_ms <= MAX_DURATION_RESET;
      arm_timeout_ms  <= ARM_TIMEOUT_RESET;
      invert_mask     <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_DUTY:     max_duty        <= cfg_data[MAG_W-1:0];
        REG_MAX_DURATION: max_duration_ms <= cfg_data;
        REG_ARM_TIMEOUT:  arm_timeout_ms  <= cfg_data;
        REG_INVERT_MASK:  invert_mask     <= cfg_data[REPORTED-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag <= 1'b0;
      watchdog   <= '0;
      last_error <= ERR_NONE;
      out_valid  <= 1'b0;
      for (int i = 0; i < MOTOR_TOTAL; i++) begin
        stop_cnt[i]   <= '0;
        motor_duty[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        armed_flag <= armed_flag_next;
        watchdog   <= watchdog_next;
        last_error <= last_error_next;
        for (int i = 0; i < MOTOR_TOTAL; i++) begin
          stop_cnt[i]   <= stop_cnt_next[i];
          motor_duty[i] <= motor_duty_next[i];
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      accepted              <= ok;
      error_code            <= last_error_next;
      is_armed              <= armed_flag_next;
      direction_bits        <= dir;
      magnitude_motor_one   <= mag[0];
      magnitude_motor_two   <= mag[1];
      magnitude_motor_three <= mag[2];
      magnitude_motor_four  <= mag[3];
    end
  end

  // disarmed always means the watchdog is parked at zero
  a_disarmed_watchdog_idle: assert property (@(posedge clk) disable iff (rst)
    !armed_flag |-> watchdog == '0)
    else $error("watchdog running while disarmed");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request produced no result");

  a_disarm_stops_all: assert property (@(posedge clk) disable iff (rst)
    in_accept && (action == ACT_DISARM) |=>
      !armed_flag && (last_error == ERR_DISARMED) && (stop_cnt[0] == '0) &&
      (motor_duty[0] == '0))
    else $error("disarm left motor running");

  a_watchdog_expiry: assert property (@(posedge clk) disable iff (rst)
    in_accept && (action == ACT_TICK) && armed_flag && (watchdog == TIMER_BITS'(1)) |=>
      !armed_flag && (last_error == ERR_ARM_TIMEOUT) && !is_armed)
    else $error("watchdog expiry did not disarm");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for armed_motor_pulse_controller_unit: directed and random requests
// with a scoreboard class that predicts every result; depends on ampc_pkg and the unit
`timescale 1ns / 1ps

module testbench;
  import ampc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = ACTION_W'(int'(ACT_WHEELS) + 1);
  localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = '1;

  typedef struct {
    logic [ACTION_W-1:0]    action;
    logic [MOTOR_NUM_W-1:0] motor;
    duty_in_t               pulse;
    duty_in_t               wheel[REPORTED];
    logic [DURATION_W-1:0]  dur;
  } motor_cmd_t;

  typedef struct {
    logic               ok;
    logic [ERROR_W-1:0] err;
    logic               armed;
    logic [REPORTED-1:0] dir;
    logic [MAG_W-1:0]   mag[REPORTED];
  } drive_status_t;

  class motor_scoreboard;
    logic [MAG_W-1:0]      duty_limit;
    logic [DURATION_W-1:0] run_max;
    logic [DURATION_W-1:0] arm_reload;
    logic [REPORTED-1:0]   invert;
    logic                  armed;
    logic [DURATION_W-1:0] watchdog;
    logic [DURATION_W-1:0] run_left[REPORTED];
    duty_t                 duty[REPORTED];
    err_t                  last_err;
    drive_status_t         due[$];
    int                    errors;

    function new();
      duty_limit = MAX_DUTY_RESET;
      run_max    = MAX_DURATION_RESET;
      arm_reload = ARM_TIMEOUT_RESET;
      invert     = '0;
      armed      = 1'b0;
      watchdog   = '0;
      last_err   = ERR_NONE;
      errors     = 0;
      halt_all();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_MAX_DUTY:     duty_limit = v[MAG_W-1:0];
        REG_MAX_DURATION: run_max = v;
        REG_ARM_TIMEOUT:  arm_reload = v;
        REG_INVERT_MASK:  invert = v[REPORTED-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void halt_all();
      foreach (duty[i]) begin
        duty[i] = '0;
        run_left[i] = '0;
      end
    endfunction

    function duty_t sat(duty_in_t d);
      int lim;
      int v;
      lim = int'(duty_limit);
      v = int'(d);
      if (v > lim) v = lim;
      else if (v < -lim) v = -lim;
      return duty_t'(v);
    endfunction

    // clamp to the register first, then lift to one tick
    function logic [DURATION_W-1:0] run_len(logic [DURATION_W-1:0] d);
      logic [DURATION_W-1:0] v;
      v = d;
      if (v > run_max) v = run_max;
      if (v == '0) v = 1;
      return v;
    endfunction

    function void note(motor_cmd_t c);
      drive_status_t s;
      duty_t d[REPORTED];
      logic ok;
      logic motion;
      logic timed_out;
      int idx;
      int a;
      ok = 1'b1;
      timed_out = 1'b0;
      motion = 1'b0;
      case (c.action)
        ACT_TICK: begin
          if (armed) begin
            if (watchdog != '0) watchdog = watchdog - 1'b1;
            if (watchdog == '0) begin
              halt_all();
              armed = 1'b0;
              last_err = ERR_ARM_TIMEOUT;
              timed_out = 1'b1;
            end
          end
          if (!timed_out) begin
            foreach (run_left[i]) begin
              if (run_left[i] != '0) begin
                run_left[i] = run_left[i] - 1'b1;
                if (run_left[i] == '0) duty[i] = '0;
              end
            end
          end
        end
        ACT_ARM: begin
          halt_all();
          armed = 1'b1;
          watchdog = arm_reload;
          last_err = ERR_NONE;
        end
        ACT_DISARM: begin
          halt_all();
          armed = 1'b0;
          watchdog = '0;
          last_err = ERR_DISARMED;
        end
        ACT_PULSE: begin
          // motor number is checked before the duty
          if (c.motor < 1 || c.motor > REPORTED) begin
            last_err = ERR_BAD_MOTOR;
            ok = 1'b0;
          end else begin
            idx = int'(c.motor) - 1;
            d[0] = sat(c.pulse);
            if (d[0] == 0) begin
              duty[idx] = '0;
              run_left[idx] = '0;
              last_err = ERR_NONE;
            end else if (!armed) begin
              last_err = ERR_REFUSED;
              ok = 1'b0;
            end else begin
              watchdog = arm_reload;
              duty[idx] = d[0];
              run_left[idx] = run_len(c.dur);
              last_err = ERR_NONE;
            end
          end
        end
        ACT_WHEELS: begin
          foreach (d[i]) begin
            d[i] = sat(c.wheel[i]);
            if (d[i] != 0) motion = 1'b1;
          end
          if (!motion) begin
            halt_all();
            last_err = ERR_NONE;
          end else if (!armed) begin
            last_err = ERR_REFUSED;
            ok = 1'b0;
          end else begin
            watchdog = arm_reload;
            foreach (d[i]) begin
              duty[i] = d[i];
              run_left[i] = run_len(c.dur);
            end
            last_err = ERR_NONE;
          end
        end
        default: ok = 1'b0;
      endcase
      s.ok = ok;
      s.err = last_err;
      s.armed = armed;
      foreach (duty[i]) begin
        a = (duty[i] < 0) ? -int'(duty[i]) : int'(duty[i]);
        if (a > int'(PWM_LIMIT)) a = int'(PWM_LIMIT);
        s.mag[i] = MAG_W'(a);
        s.dir[i] = (duty[i] < 0) ^ invert[i];
      end
      due.push_back(s);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check(drive_status_t got);
      drive_status_t want;
      if (due.size() == 0) begin
        report("result with no request pending");
        return;
      end
      want = due.pop_front();
      cmp("accepted", 16'(got.ok), 16'(want.ok));
      cmp("error_code", 16'(got.err), 16'(want.err));
      cmp("is_armed", 16'(got.armed), 16'(want.armed));
      cmp("direction_bits", 16'(got.dir), 16'(want.dir));
      foreach (want.mag[i])
        cmp($sformatf("magnitude of motor %0d", i + 1), 16'(got.mag[i]), 16'(want.mag[i]));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_write_enable;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [ACTION_W-1:0] action;
  logic [MOTOR_NUM_W-1:0] motor_number;
  logic signed [DUTY_IN_W-1:0] pulse_duty;
  logic signed [DUTY_IN_W-1:0] duty_front_left;
  logic signed [DUTY_IN_W-1:0] duty_front_right;
  logic signed [DUTY_IN_W-1:0] duty_rear_left;
  logic signed [DUTY_IN_W-1:0] duty_rear_right;
  logic [DURATION_W-1:0] duration_ms;
  logic out_valid;
  logic out_stall;
  logic accepted;
  logic [ERROR_W-1:0] error_code;
  logic is_armed;
  logic [REPORTED-1:0] direction_bits;
  logic [MAG_W-1:0] magnitude_motor_one;
  logic [MAG_W-1:0] magnitude_motor_two;
  logic [MAG_W-1:0] magnitude_motor_three;
  logic [MAG_W-1:0] magnitude_motor_four;

  motor_scoreboard sb;
  int  cycle_count;
  int  hold_request;
  int  hold_left;
  int  stall_left;
  bit  quiet;

  armed_motor_pulse_controller_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .motor_number(motor_number), .pulse_duty(pulse_duty),
    .duty_front_left(duty_front_left), .duty_front_right(duty_front_right),
    .duty_rear_left(duty_rear_left), .duty_rear_right(duty_rear_right),
    .duration_ms(duration_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .error_code(error_code), .is_armed(is_armed),
    .direction_bits(direction_bits),
    .magnitude_motor_one(magnitude_motor_one), .magnitude_motor_two(magnitude_motor_two),
    .magnitude_motor_three(magnitude_motor_three), .magnitude_motor_four(magnitude_motor_four)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly short gaps, now and then a long one
  function int idle_len();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 87) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // receiver side: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(99) < 30) begin
      stall_left = idle_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    drive_status_t s;
    if (!rst && out_valid && !out_stall) begin
      s.ok = accepted;
      s.err = error_code;
      s.armed = is_armed;
      s.dir = direction_bits;
      s.mag[0] = magnitude_motor_one;
      s.mag[1] = magnitude_motor_two;
      s.mag[2] = magnitude_motor_three;
      s.mag[3] = magnitude_motor_four;
      sb.check(s);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  function motor_cmd_t mk(logic [ACTION_W-1:0] act, int m, int p,
                          int fl, int fr, int rl, int rr, int dur);
    motor_cmd_t c;
    c.action = act;
    c.motor = MOTOR_NUM_W'(m);
    c.pulse = DUTY_IN_W'(p);
    c.wheel[0] = DUTY_IN_W'(fl);
    c.wheel[1] = DUTY_IN_W'(fr);
    c.wheel[2] = DUTY_IN_W'(rl);
    c.wheel[3] = DUTY_IN_W'(rr);
    c.dur = DURATION_W'(dur);
    return c;
  endfunction

  function duty_in_t pick_duty();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) begin
      case ($urandom_range(5))
        0: return -12'sd2048;
        1: return 12'sd2047;
        2: return -12'sd1023;
        3: return 12'sd1023;
        4: return -12'sd1;
        default: return 12'sd1;
      endcase
    end
    if (r < 65) begin
      if ($urandom_range(1)) return DUTY_IN_W'($urandom_range(300, 1));
      return -DUTY_IN_W'($urandom_range(300, 1));
    end
    return DUTY_IN_W'($urandom);
  endfunction

  function logic [DURATION_W-1:0] pick_run();
    int r;
    r = $urandom_range(99);
    if (r < 60) return DURATION_W'($urandom_range(8));
    if (r < 85) return DURATION_W'($urandom_range(60));
    return DURATION_W'($urandom);
  endfunction

  // ticks dominate so stop timers and the watchdog actually run down
  function motor_cmd_t random_cmd();
    motor_cmd_t c;
    int pick;
    c.motor = MOTOR_NUM_W'($urandom);
    c.pulse = DUTY_IN_W'($urandom);
    foreach (c.wheel[i]) c.wheel[i] = DUTY_IN_W'($urandom);
    c.dur = DURATION_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 38) c.action = ACT_TICK;
    else if (pick < 46) c.action = ACT_ARM;
    else if (pick < 49) c.action = ACT_DISARM;
    else if (pick < 72) begin
      c.action = ACT_PULSE;
      if ($urandom_range(9) != 0) c.motor = MOTOR_NUM_W'($urandom_range(REPORTED, 1));
      c.pulse = pick_duty();
      c.dur = pick_run();
    end else if (pick < 96) begin
      c.action = ACT_WHEELS;
      if ($urandom_range(9) == 0) begin
        foreach (c.wheel[i]) c.wheel[i] = '0;
      end else begin
        foreach (c.wheel[i]) c.wheel[i] = pick_duty();
      end
      c.dur = pick_run();
    end else begin
      c.action = ACTION_W'($urandom_range(int'(ACT_LAST_UNUSED), int'(ACT_FIRST_UNUSED)));
    end
    return c;
  endfunction

  task send_req(motor_cmd_t c);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= c.action;
    motor_number <= c.motor;
    pulse_duty <= c.pulse;
    duty_front_left <= c.wheel[0];
    duty_front_right <= c.wheel[1];
    duty_rear_left <= c.wheel[2];
    duty_rear_right <= c.wheel[3];
    duration_ms <= c.dur;
    do @(posedge clk); while (in_stall);
    sb.note(c);
    @(negedge clk);
  endtask

  // wait until every request has its result, then let the pipe drain
  task settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task configure(int duty_lim, int run_max, int wd, int inv);
    put_reg(REG_MAX_DUTY, CFG_DATA_W'(duty_lim));
    put_reg(REG_MAX_DURATION, CFG_DATA_W'(run_max));
    put_reg(REG_ARM_TIMEOUT, CFG_DATA_W'(wd));
    put_reg(REG_INVERT_MASK, CFG_DATA_W'(inv));
    cfg_write_enable <= 1'b0;
  endtask

  task run_random(int n, int hold);
    if (hold > 0) begin
      @(posedge clk);
      hold_request = hold;
      @(negedge clk);
    end
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(3) == 0);
      send_req(random_cmd());
    end
    quiet = 1'b0;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = '0;
    motor_number = '0;
    pulse_duty = '0;
    duty_front_left = '0;
    duty_front_right = '0;
    duty_rear_left = '0;
    duty_rear_right = '0;
    duration_ms = '0;
    out_stall = 1'b0;
    hold_request = 0;
    hold_left = 0;
    stall_left = 0;
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: refusals while disarmed, zero-duty stops, bad motors, clamps
    send_req(mk(ACT_PULSE, 1, 100, 0, 0, 0, 0, 10));
    send_req(mk(ACT_WHEELS, 0, 0, 5, 0, 0, 0, 10));
    send_req(mk(ACT_PULSE, 2, 0, 0, 0, 0, 0, 10));
    send_req(mk(ACT_WHEELS, 0, 0, 0, 0, 0, 0, 10));
    send_req(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_FIRST_UNUSED, 1, 50, 1, 1, 1, 1, 5));
    send_req(mk(ACT_LAST_UNUSED, 1, 50, 1, 1, 1, 1, 5));
    send_req(mk(ACT_ARM, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_PULSE, 0, 100, 0, 0, 0, 0, 10));
    send_req(mk(ACT_PULSE, REPORTED + 1, 100, 0, 0, 0, 0, 10));
    send_req(mk(ACT_PULSE, 255, 0, 0, 0, 0, 0, 10));
    send_req(mk(ACT_PULSE, 4, -2048, 0, 0, 0, 0, 0));
    send_req(mk(ACT_PULSE, 1, 2047, 0, 0, 0, 0, 65535));
    send_req(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_WHEELS, 0, 0, -2048, 2047, -1, 1, 3));
    send_req(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_PULSE, 3, 0, 0, 0, 0, 0, 7));
    send_req(mk(ACT_DISARM, 0, 0, 0, 0, 0, 0, 0));
    settle();

    // zero duty limit: every command clamps to a stop
    configure(0, 65535, 65535, 15);
    run_random(100, 0);
    settle();

    // one-tick watchdog and one-tick runs
    configure(1023, 1, 1, 0);
    send_req(mk(ACT_ARM, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_PULSE, 2, -500, 0, 0, 0, 0, 9));
    send_req(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    run_random(150, 0);
    settle();

    // mid-range settings, with a long receiver hold-off to back the unit up
    configure($urandom_range(1023, 1), $urandom_range(30, 2), $urandom_range(60, 5),
              $urandom_range(15));
    run_random(250, 300);
    settle();

    // zero registers: runs still last one tick, the watchdog is already spent
    configure(512, 0, 0, 5);
    send_req(mk(ACT_ARM, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_PULSE, 1, 300, 0, 0, 0, 0, 100));
    send_req(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    run_random(100, 0);
    settle();

    configure(1023, 5000, 2000, $urandom_range(15));
    run_random(200, 200);
    settle();

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ampc_pkg.sv
rtl/armed_motor_pulse_controller_unit.sv
tb/testbench.sv
